// ----- rtl/core/mi3_pkg.sv -----
// Package for the 3x3 fixed-point matrix inverse core.
// Element widths, derived word widths and shared types; no dependencies.
`timescale 1ns / 1ps

package mi3_pkg;

   // Element format: signed, EW bits with FB fraction bits
   localparam int EW   = 16;
   localparam int FB   = 12;
   localparam int ROWW = 3 * EW;

   // Derived widths
   localparam int PW   = 2 * EW;           // element product
   localparam int CW   = PW + 1;           // cross product term
   localparam int DPW  = CW + EW;          // determinant partial product
   localparam int DETW = DPW + 2;          // determinant
   localparam int DW   = DETW;             // determinant magnitude
   localparam int NS   = 2 * FB;           // numerator scaling shift
   localparam int QB   = EW + 1;           // quotient bits kept
   localparam int NWID = (CW + NS > DW) ? CW + NS + QB : DW + QB;

   // Pipeline depths
   localparam int FRONT_LAT = 4;
   localparam int LANE_LAT  = QB + 2;
   localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + 1;

   // Saturation limits
   localparam logic [EW-1:0] ELEM_MAX = EW'(2 ** (EW - 1) - 1);
   localparam logic [EW-1:0] ELEM_MIN = EW'(2 ** (EW - 1));
   localparam logic [QB:0]   QPOS_MAX = (QB + 1)'(2 ** (EW - 1) - 1);
   localparam logic [QB:0]   QNEG_MAX = (QB + 1)'(2 ** (EW - 1));

   typedef logic signed [EW-1:0]   elem_type;
   typedef logic signed [PW-1:0]   prod_type;
   typedef logic signed [CW-1:0]   cross_type;
   typedef logic signed [DPW-1:0]  dprod_type;
   typedef logic signed [DETW-1:0] det_type;
   typedef logic [ROWW-1:0]        word_type;

   // Result of one divider lane
   typedef struct packed {
      logic [EW-1:0] code;
      logic          sat;
   } lane_out_type;

endpackage

// ----- rtl/core/mi3_cross.sv -----
// Front end: cross products of the columns and the determinant.
// Four register stages; uses mi3_pkg.
`timescale 1ns / 1ps

module mi3_cross (
   input  logic               clock,
   input  logic               en,
   input  mi3_pkg::word_type  col0,
   input  mi3_pkg::word_type  col1,
   input  mi3_pkg::word_type  col2,
   output mi3_pkg::cross_type crs [0:8],
   output mi3_pkg::det_type   det
);
   import mi3_pkg::*;

   elem_type  vec [0:2][0:2];
   prod_type  prod_in [0:17];
   prod_type  prod_ff [0:17];
   elem_type  c1_ff [0:2];
   elem_type  c2_ff [0:2];
   cross_type crs2_ff [0:8];
   cross_type crs3_ff [0:8];
   cross_type crs4_ff [0:8];
   dprod_type dp_ff [0:2];
   det_type   det_ff;

   // Unpack the three columns
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vec[0][k] = col0[k*EW +: EW];
         vec[1][k] = col1[k*EW +: EW];
         vec[2][k] = col2[k*EW +: EW];
      end
   end

   // Row i is vec[i+1] x vec[i+2]; two products per term
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[(i*3+k)*2]   = vec[(i+1)%3][(k+1)%3] * vec[(i+2)%3][(k+2)%3];
            prod_in[(i*3+k)*2+1] = vec[(i+1)%3][(k+2)%3] * vec[(i+2)%3][(k+1)%3];
         end
      end
   end

   // Stage 1: products
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         c1_ff   <= vec[2];
      end
   end

   // Stage 2: cross product terms
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 9; j++)
            crs2_ff[j] <= cross_type'(prod_ff[2*j]) - cross_type'(prod_ff[2*j+1]);
         c2_ff <= c1_ff;
      end
   end

   // Stage 3: (a x b) times c, per element
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++)
            dp_ff[k] <= crs2_ff[6+k] * c2_ff[k];
         crs3_ff <= crs2_ff;
      end
   end

   // Stage 4: determinant sum
   always_ff @(posedge clock) begin
      if (en) begin
         det_ff  <= det_type'(dp_ff[0]) + det_type'(dp_ff[1]) + det_type'(dp_ff[2]);
         crs4_ff <= crs3_ff;
      end
   end

   assign crs = crs4_ff;
   assign det = det_ff;

endmodule

// ----- rtl/core/mi3_div_lane.sv -----
// One divider lane: round(num * 2^NS / det), saturated to an element.
// Restoring division, one quotient bit per stage; uses mi3_pkg.
`timescale 1ns / 1ps

module mi3_div_lane (
   input  logic                  clock,
   input  logic                  en,
   input  mi3_pkg::cross_type    num,
   input  mi3_pkg::det_type      det,
   output mi3_pkg::lane_out_type res
);
   import mi3_pkg::*;

   logic [CW-1:0]   n_mag;
   logic [DW-1:0]   d_mag;
   logic [NWID-1:0] n_wide;
   logic [NWID-1:0] d_wide;

   logic [DW-1:0] rem_ff [0:QB];
   logic [QB-1:0] q_ff   [0:QB];
   logic [QB-1:0] lo_ff  [0:QB];
   logic [DW-1:0] d_ff   [0:QB];
   logic          neg_ff [0:QB];
   logic          ovf_ff [0:QB];
   logic          nz_ff  [0:QB];

   logic          rnd;
   logic [QB:0]   qr;
   logic [EW-1:0] qlo;
   logic          over;
   lane_out_type  res_in;
   lane_out_type  res_ff;

   // Magnitudes and scaled operands
   always_comb begin
      n_mag  = num[CW-1] ? CW'(-num) : CW'(num);
      d_mag  = det[DETW-1] ? DW'(-det) : DW'(det);
      n_wide = NWID'(n_mag) << NS;
      d_wide = NWID'(d_mag) << QB;
   end

   // Stage 0: setup; overflow when the quotient needs more than QB bits
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DW'(n_wide >> QB);
         lo_ff[0]  <= n_wide[QB-1:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= d_mag;
         neg_ff[0] <= num[CW-1] ^ det[DETW-1];
         ovf_ff[0] <= n_wide >= d_wide;
         nz_ff[0]  <= n_mag != '0;
      end
   end

   // One quotient bit per stage
   for (genvar j = 1; j <= QB; j++) begin : g_step
      logic [DW:0] t;
      logic        take;
      assign t    = {rem_ff[j-1], lo_ff[j-1][QB-1]};
      assign take = t >= {1'b0, d_ff[j-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= take ? DW'(t - {1'b0, d_ff[j-1]}) : DW'(t);
            q_ff[j]   <= {q_ff[j-1][QB-2:0], take};
            lo_ff[j]  <= lo_ff[j-1] << 1;
            d_ff[j]   <= d_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
            nz_ff[j]  <= nz_ff[j-1];
         end
      end
   end

   // Round to nearest, ties away, then clamp
   always_comb begin
      rnd  = {rem_ff[QB], 1'b0} >= {1'b0, d_ff[QB]};
      qr   = (QB + 1)'(q_ff[QB]) + (QB + 1)'(rnd);
      qlo  = qr[EW-1:0];
      over = ovf_ff[QB] || (neg_ff[QB] ? (qr > QNEG_MAX) : (qr > QPOS_MAX));
      if (!nz_ff[QB]) begin
         res_in.code = '0;
      end else if (over) begin
         res_in.code = neg_ff[QB] ? ELEM_MIN : ELEM_MAX;
      end else begin
         res_in.code = neg_ff[QB] ? EW'(-qlo) : qlo;
      end
      res_in.sat = nz_ff[QB] && over;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/core/mi3_merge.sv -----
// Merge stage: packs the nine lane results into rows and combines flags.
// Output register of the core; uses mi3_pkg.
`timescale 1ns / 1ps

module mi3_merge (
   input  logic                  clock,
   input  logic                  en,
   input  mi3_pkg::lane_out_type lane [0:8],
   input  logic                  zero,
   output mi3_pkg::word_type     row0,
   output mi3_pkg::word_type     row1,
   output mi3_pkg::word_type     row2,
   output logic                  singular,
   output logic                  saturated
);
   import mi3_pkg::*;

   word_type rows_in [0:2];
   word_type rows_ff [0:2];
   logic     sat_in;
   logic     sing_ff;
   logic     sat_ff;

   // Pack rows; a singular matrix forces zeros
   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            rows_in[i][k*EW +: EW] = zero ? '0 : lane[i*3+k].code;
            sat_in = sat_in | lane[i*3+k].sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rows_ff <= rows_in;
         sing_ff <= zero;
         sat_ff  <= sat_in && !zero;
      end
   end

   assign row0      = rows_ff[0];
   assign row1      = rows_ff[1];
   assign row2      = rows_ff[2];
   assign singular  = sing_ff;
   assign saturated = sat_ff;

endmodule

// ----- rtl/core/matrix_inverse_3x3_core.sv -----
// Top level of the 3x3 matrix inverse core (adjugate over determinant).
// Instantiates mi3_cross, nine mi3_div_lane and mi3_merge; uses mi3_pkg.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | col0, col1, col2
//   rsp     | out       | rsp_valid/rsp_stall | row0..row2, singular, saturated
//
// One transaction per cycle sustained while no result waits under rsp_stall; the
// path runs through the front end, the bit-per-stage restoring dividers in the nine
// lanes, then the merge register.
// Synchronous active-high reset clears the valid pipeline only.
// The pipeline holds as a whole while a result waits under rsp_stall;
// req_stall is raised only in that case.
`timescale 1ns / 1ps

module matrix_inverse_3x3_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mi3_pkg::word_type req_col0,
   input  mi3_pkg::word_type req_col1,
   input  mi3_pkg::word_type req_col2,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mi3_pkg::word_type rsp_row0,
   output mi3_pkg::word_type rsp_row1,
   output mi3_pkg::word_type rsp_row2,
   output logic              rsp_singular,
   output logic              rsp_saturated
);
   import mi3_pkg::*;

   logic                 en;
   logic [TOTAL_LAT-1:0] valid_ff;
   logic [TOTAL_LAT-1:0] valid_in;
   cross_type            crs [0:8];
   det_type              det;
   lane_out_type         lane [0:8];
   logic [LANE_LAT-1:0]  zero_ff;

   // Global advance
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = valid_ff[TOTAL_LAT-1];

   // Valid pipeline
   assign valid_in = {valid_ff[TOTAL_LAT-2:0], req_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   mi3_cross u_cross (
      .clock (clock),
      .en    (en),
      .col0  (req_col0),
      .col1  (req_col1),
      .col2  (req_col2),
      .crs   (crs),
      .det   (det)
   );

   // Nine divider lanes, one per result element
   for (genvar i = 0; i < 9; i++) begin : g_lane
      mi3_div_lane u_lane (
         .clock (clock),
         .en    (en),
         .num   (crs[i]),
         .det   (det),
         .res   (lane[i])
      );
   end

   // Singular flag tracks the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= {zero_ff[LANE_LAT-2:0], det == '0};
      end
   end

   mi3_merge u_merge (
      .clock     (clock),
      .en        (en),
      .lane      (lane),
      .zero      (zero_ff[LANE_LAT-1]),
      .row0      (rsp_row0),
      .row1      (rsp_row1),
      .row2      (rsp_row2),
      .singular  (rsp_singular),
      .saturated (rsp_saturated)
   );

endmodule

// ----- rtl/core/mi3_checker.sv -----
// Port-level checker for matrix_inverse_3x3_core, bound to the top level.
// Uses mi3_pkg for the word type.
`timescale 1ns / 1ps

module mi3_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mi3_pkg::word_type req_col0,
   input mi3_pkg::word_type req_col1,
   input mi3_pkg::word_type req_col2,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mi3_pkg::word_type rsp_row0,
   input mi3_pkg::word_type rsp_row1,
   input mi3_pkg::word_type rsp_row2,
   input logic              rsp_singular,
   input logic              rsp_saturated
);

   // Singular result carries zero rows and no saturation
   a_singular: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |->
         rsp_row0 == '0 && rsp_row1 == '0 && rsp_row2 == '0 && !rsp_saturated)
      else $error("singular result not cleared");

   // Input is held back only by a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // A stalled result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row0) && $stable(rsp_row1)
         && $stable(rsp_row2) && $stable(rsp_singular) && $stable(rsp_saturated))
      else $error("stalled result changed");

endmodule

bind matrix_inverse_3x3_core mi3_checker u_mi3_checker (.*);
